@@ src/csmc_pkg.sv @@
// Shared types and constants for the circular stone merge cost block.
// Used by csmc_ctrl, csmc_dp and the top module; depends on nothing else.
`timescale 1ns / 1ps
package csmc_pkg;

  localparam int IN_WEIGHT_W = 16;
  localparam int COST_OUT_W  = 28;

  typedef struct packed {
    logic [IN_WEIGHT_W-1:0] pile_weight;
    logic                   last_pile;
  } in_t;

  typedef struct packed {
    logic [COST_OUT_W-1:0] least_cost;
    logic [COST_OUT_W-1:0] greatest_cost;
    logic                  overflow;
  } out_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_SUM_RD,
    ST_SUM_WR,
    ST_K_RD,
    ST_K_ACC,
    ST_CELL_WR,
    ST_FIN_RD,
    ST_FIN_ACC,
    ST_OUT
  } state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_we;
    logic init_wr;
    logic sum_wr;
    logic k_acc;
    logic k_first;
    logic cell_wr;
    logic fin_acc;
    logic fin_first;
  } cmd_t;

endpackage

@@ src/csmc_ram.sv @@
// Generic single-write, dual-read RAM with registered read data.
// Stand-alone; used for the pile store, run sums and cost tables.
`timescale 1ns / 1ps
module csmc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         qa,
  output logic [WIDTH-1:0]         qb
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    qa <= mem[raddr_a];
    qb <= mem[raddr_b];
  end

endmodule

@@ src/csmc_ctrl.sv @@
// Sequencer for the ring interval computation: loop counters, addresses, commands.
// Depends on csmc_pkg.
`timescale 1ns / 1ps
module csmc_ctrl import csmc_pkg::*; #(
  parameter int MAX_PILES = 64,
  parameter int IB = 6,
  parameter int CB = 7
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_last,
  output logic          in_stall,
  input  logic          out_free,
  output logic          out_load,
  output logic          ovf,
  output cmd_t          cmd,
  output logic [IB-1:0] pile_waddr,
  output logic [IB-1:0] pile_raddr,
  output logic [IB-1:0] rs_addr,
  output logic [2*IB-1:0] tab_wa,
  output logic [2*IB-1:0] tab_ra,
  output logic [2*IB-1:0] tab_rb
);

  state_t state_r, state_nxt;
  logic [IB-1:0] s_r, s_nxt, len_r, len_nxt, k_r, k_nxt;
  logic [CB-1:0] n_r, n_nxt, cnt_r, cnt_nxt;
  logic ovf_r, ovf_nxt;

  logic [IB-1:0] nm1, len_m1, rest;
  logic [IB:0]   n_ext, sum_sl, sum_t, mod_sl, mod_t;
  logic          has_room;

  assign nm1      = IB'(n_r - 1'b1);
  assign len_m1   = len_r - 1'b1;
  assign rest     = len_r - k_r - 1'b1;
  assign n_ext    = (IB+1)'(n_r);
  assign sum_sl   = {1'b0, s_r} + {1'b0, len_r};
  assign sum_t    = {1'b0, s_r} + {1'b0, k_r} + 1'b1;
  assign mod_sl   = (sum_sl >= n_ext) ? sum_sl - n_ext : sum_sl;
  assign mod_t    = (sum_t >= n_ext) ? sum_t - n_ext : sum_t;
  assign has_room = cnt_r < CB'(MAX_PILES);

  assign ovf        = ovf_r;
  assign pile_waddr = cnt_r[IB-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ovf_r   <= ovf_nxt;
    end
    s_r   <= s_nxt;
    len_r <= len_nxt;
    k_r   <= k_nxt;
    n_r   <= n_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    s_nxt      = s_r;
    len_nxt    = len_r;
    k_nxt      = k_r;
    n_nxt      = n_r;
    cnt_nxt    = cnt_r;
    ovf_nxt    = ovf_r;
    cmd        = '0;
    in_stall   = 1'b1;
    out_load   = 1'b0;
    pile_raddr = s_r;
    rs_addr    = s_r;
    tab_wa     = {s_r, len_r};
    tab_ra     = {s_r, k_r};
    tab_rb     = {mod_t[IB-1:0], rest};
    unique case (state_r)
      ST_LOAD: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (has_room) begin
            cmd.load_we = 1'b1;
            cnt_nxt     = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last) begin
            n_nxt     = has_room ? cnt_r + 1'b1 : cnt_r;
            s_nxt     = '0;
            state_nxt = ST_INIT_RD;
          end
        end
      end
      ST_INIT_RD: state_nxt = ST_INIT_WR;
      ST_INIT_WR: begin
        cmd.init_wr = 1'b1;
        tab_wa      = {s_r, {IB{1'b0}}};
        if (s_r == nm1) begin
          s_nxt = '0;
          if (nm1 == '0) begin
            len_nxt   = '0;
            state_nxt = ST_FIN_RD;
          end else begin
            len_nxt   = IB'(1);
            state_nxt = ST_SUM_RD;
          end
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_INIT_RD;
        end
      end
      ST_SUM_RD: begin
        pile_raddr = mod_sl[IB-1:0];
        k_nxt      = '0;
        state_nxt  = ST_SUM_WR;
      end
      ST_SUM_WR: begin
        cmd.sum_wr = 1'b1;
        state_nxt  = ST_K_RD;
      end
      ST_K_RD: state_nxt = ST_K_ACC;
      ST_K_ACC: begin
        cmd.k_acc   = 1'b1;
        cmd.k_first = (k_r == '0);
        if (k_r == len_m1) begin
          state_nxt = ST_CELL_WR;
        end else begin
          k_nxt     = k_r + 1'b1;
          state_nxt = ST_K_RD;
        end
      end
      ST_CELL_WR: begin
        cmd.cell_wr = 1'b1;
        if (s_r == nm1) begin
          s_nxt = '0;
          if (len_r == nm1) begin
            state_nxt = ST_FIN_RD;
          end else begin
            len_nxt   = len_r + 1'b1;
            state_nxt = ST_SUM_RD;
          end
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_SUM_RD;
        end
      end
      ST_FIN_RD: begin
        tab_ra    = {s_r, nm1};
        state_nxt = ST_FIN_ACC;
      end
      ST_FIN_ACC: begin
        cmd.fin_acc   = 1'b1;
        cmd.fin_first = (s_r == '0);
        if (s_r == nm1) begin
          state_nxt = ST_OUT;
        end else begin
          s_nxt     = s_r + 1'b1;
          state_nxt = ST_FIN_RD;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_load  = 1'b1;
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: state_nxt = ST_LOAD;
    endcase
  end

endmodule

@@ src/csmc_dp.sv @@
// Datapath: pile store, run sums, least and greatest cost tables, accumulators.
// Depends on csmc_pkg and csmc_ram.
`timescale 1ns / 1ps
module csmc_dp import csmc_pkg::*; #(
  parameter int IB = 6,
  parameter int WB = 16,
  parameter int SW = 23,
  parameter int CW = 30
) (
  input  logic                  clk,
  input  cmd_t                  cmd,
  input  logic [WB-1:0]         weight,
  input  logic [IB-1:0]         pile_waddr,
  input  logic [IB-1:0]         pile_raddr,
  input  logic [IB-1:0]         rs_addr,
  input  logic [2*IB-1:0]       tab_wa,
  input  logic [2*IB-1:0]       tab_ra,
  input  logic [2*IB-1:0]       tab_rb,
  output logic [COST_OUT_W-1:0] least_cost,
  output logic [COST_OUT_W-1:0] greatest_cost
);

  localparam int XW = (CW > COST_OUT_W) ? CW : COST_OUT_W;
  localparam logic [XW-1:0] COST_MAX = XW'((64'd1 << COST_OUT_W) - 64'd1);

  logic [WB-1:0] pile_q;
  logic [SW-1:0] rs_q, rs_wdata, sum_r;
  logic [CW-1:0] lo_qa, lo_qb, hi_qa, hi_qb, lo_w, hi_w;
  logic [CW-1:0] lo_best_r, hi_best_r, fin_lo_r, fin_hi_r, lo_pair, hi_pair;
  logic          tab_we;

  assign rs_wdata = cmd.init_wr ? SW'(pile_q) : rs_q + SW'(pile_q);
  assign tab_we   = cmd.init_wr | cmd.cell_wr;
  assign lo_w     = cmd.init_wr ? '0 : lo_best_r + CW'(sum_r);
  assign hi_w     = cmd.init_wr ? '0 : hi_best_r + CW'(sum_r);
  assign lo_pair  = lo_qa + lo_qb;
  assign hi_pair  = hi_qa + hi_qb;

  csmc_ram #(.WIDTH(WB), .DEPTH(2**IB)) u_piles (
    .clk, .we(cmd.load_we), .waddr(pile_waddr), .wdata(weight),
    .raddr_a(pile_raddr), .raddr_b(pile_raddr), .qa(pile_q), .qb()
  );

  csmc_ram #(.WIDTH(SW), .DEPTH(2**IB)) u_sums (
    .clk, .we(cmd.init_wr | cmd.sum_wr), .waddr(rs_addr), .wdata(rs_wdata),
    .raddr_a(rs_addr), .raddr_b(rs_addr), .qa(rs_q), .qb()
  );

  csmc_ram #(.WIDTH(CW), .DEPTH(2**(2*IB))) u_least (
    .clk, .we(tab_we), .waddr(tab_wa), .wdata(lo_w),
    .raddr_a(tab_ra), .raddr_b(tab_rb), .qa(lo_qa), .qb(lo_qb)
  );

  csmc_ram #(.WIDTH(CW), .DEPTH(2**(2*IB))) u_greatest (
    .clk, .we(tab_we), .waddr(tab_wa), .wdata(hi_w),
    .raddr_a(tab_ra), .raddr_b(tab_rb), .qa(hi_qa), .qb(hi_qb)
  );

  always_ff @(posedge clk) begin
    if (cmd.sum_wr) begin
      sum_r <= rs_wdata;
    end
    if (cmd.k_acc) begin
      if (cmd.k_first || lo_pair < lo_best_r) begin
        lo_best_r <= lo_pair;
      end
      if (cmd.k_first || hi_pair > hi_best_r) begin
        hi_best_r <= hi_pair;
      end
    end
    if (cmd.fin_acc) begin
      if (cmd.fin_first || lo_qa < fin_lo_r) begin
        fin_lo_r <= lo_qa;
      end
      if (cmd.fin_first || hi_qa > fin_hi_r) begin
        fin_hi_r <= hi_qa;
      end
    end
  end

  // Costs beyond the output range saturate to all ones.
  assign least_cost    = (XW'(fin_lo_r) > COST_MAX) ? COST_MAX[COST_OUT_W-1:0]
                                                    : COST_OUT_W'(fin_lo_r);
  assign greatest_cost = (XW'(fin_hi_r) > COST_MAX) ? COST_MAX[COST_OUT_W-1:0]
                                                    : COST_OUT_W'(fin_hi_r);

endmodule

@@ src/circular_stone_merge_cost.sv @@
// Circular stone merge cost: least and greatest cost of merging a ring of piles.
// Piles load at one per cycle while the block is in its load state. For an n-pile ring it
// seeds the single-pile runs, forms each longer run's sum and least and greatest split
// cost, sweeps over the starting piles and loads the output. RAM read data is registered,
// so each read has its own state. One ring at a time; a stalled result holds the input off
// longer. Reset (rst_n low, synchronous) empties the pile count and the output.
`timescale 1ns / 1ps
module circular_stone_merge_cost import csmc_pkg::*; #(
  parameter int MAX_PILES   = 64,
  parameter int WEIGHT_BITS = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // Index width for piles, count width, stored weight, run sum and cost widths.
  localparam int IB = (MAX_PILES > 1) ? $clog2(MAX_PILES) : 1;
  localparam int CB = $clog2(MAX_PILES + 1);
  localparam int WB = (WEIGHT_BITS < IN_WEIGHT_W) ? WEIGHT_BITS : IN_WEIGHT_W;
  localparam int SW = WB + CB;
  localparam int CW = WB + 2 * CB;

  cmd_t cmd;
  logic [IB-1:0]   pile_waddr, pile_raddr, rs_addr;
  logic [2*IB-1:0] tab_wa, tab_ra, tab_rb;
  logic [COST_OUT_W-1:0] least_cost, greatest_cost;
  logic out_free, out_load, ovf;
  logic out_valid_r;
  out_t out_data_r;

  // The output register is free when empty or when its transfer completes this cycle.
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  csmc_ctrl #(.MAX_PILES(MAX_PILES), .IB(IB), .CB(CB)) u_ctrl (
    .clk, .rst_n,
    .in_valid, .in_last(in_data.last_pile), .in_stall,
    .out_free, .out_load, .ovf, .cmd,
    .pile_waddr, .pile_raddr, .rs_addr, .tab_wa, .tab_ra, .tab_rb
  );

  csmc_dp #(.IB(IB), .WB(WB), .SW(SW), .CW(CW)) u_dp (
    .clk, .cmd,
    .weight(in_data.pile_weight[WB-1:0]),
    .pile_waddr, .pile_raddr, .rs_addr, .tab_wa, .tab_ra, .tab_rb,
    .least_cost, .greatest_cost
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (out_load) begin
      out_data_r.least_cost    <= least_cost;
      out_data_r.greatest_cost <= greatest_cost;
      out_data_r.overflow      <= ovf;
    end
  end

endmodule
